// ----- src/cprc_pkg.sv -----
// Shared types and constants for the complex polar/rectangular converter.
package cprc_pkg;

    // Direction register codes.
    localparam logic DIR_RECT_TO_POLAR = 1'b0;
    localparam logic DIR_POLAR_TO_RECT = 1'b1;

    // Largest number of CORDIC stages that the angle table supports.
    localparam int MAX_STAGES = 24;

    // CORDIC gain compensation, 0.60725... in Q30.
    localparam logic [29:0] GAIN_Q30 = 30'h26DD3B6A;

    // Binary angles on a 32-bit circle.
    localparam logic [31:0] HALF_TURN     = 32'h8000_0000;
    localparam logic [31:0] PHASE_ROUNDER = 32'h0000_8000;

    // Phase reported for a vector on the imaginary axis.
    localparam logic signed [15:0] QUARTER_TURN_POS = 16'sd16384;
    localparam logic signed [15:0] QUARTER_TURN_NEG = -16'sd16384;

    // atan(2^-i) as 32-bit binary angles, one entry per stage.
    localparam logic [31:0] ATAN_TURNS [0:MAX_STAGES-1] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C,
        32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
        32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051
    };

    // One incoming sample.
    typedef struct packed {
        logic signed [16:0] first_in;
        logic signed [15:0] second_in;
        logic               last_in;
    } sample_t;

    // One converted sample.
    typedef struct packed {
        logic signed [16:0] first_out;
        logic signed [15:0] second_out;
        logic               last_out;
    } result_t;

endpackage

// ----- src/complex_polar_rect_convert.sv -----
// Pipelined CORDIC converter between rectangular and polar form of complex samples.
// Throughput: one transaction per cycle; every stage holds one sample and stalls
// only when the stage after it is full and cannot move.
// Each CORDIC stage is one register stage; the gain multiplies sit in stages of their own.
// Reset clears all valid bits and sets the direction to rectangular to polar;
// the datapath registers are not reset.
module complex_polar_rect_convert
    import cprc_pkg::*;
#(
    parameter int ITERATIONS = 16,
    parameter int DATA_WIDTH = 16
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    cfg_wr_en,
    input  logic    cfg_wr_data,
    input  logic    sample_valid,
    output logic    sample_ready,
    input  sample_t sample,
    output logic    result_valid,
    input  logic    result_ready,
    output result_t result
);

    // Internal word width: holds components with 16 guard bits plus CORDIC growth.
    localparam int XW       = 36;
    localparam int NST      = ITERATIONS + 4;
    localparam int CORDIC_0 = 3;
    localparam int POST     = ITERATIONS + 3;

    // Component and magnitude limits.
    localparam int    COMP_BITS = (DATA_WIDTH < 16) ? DATA_WIDTH : 16;
    localparam longint CMAX = (longint'(1) << (COMP_BITS - 1)) - 1;
    localparam longint CMIN = -(longint'(1) << (COMP_BITS - 1));
    localparam longint MAG_MAX =
        (longint'(64'd3037000500) + (longint'(1) << (31 - COMP_BITS))) >>> (32 - COMP_BITS);
    localparam longint FIRST_HI = (MAG_MAX > CMAX) ? MAG_MAX : CMAX;

    localparam logic signed [16:0]   A_CMAX   = 17'(CMAX);
    localparam logic signed [16:0]   A_CMIN   = 17'(CMIN);
    localparam logic signed [16:0]   A_MAG    = 17'(MAG_MAX);
    localparam logic signed [16:0]   A_HI     = 17'(FIRST_HI);
    localparam logic signed [15:0]   B_CMAX   = 16'(CMAX);
    localparam logic signed [15:0]   B_CMIN   = 16'(CMIN);
    localparam logic signed [XW-1:0] X_CMAX   = XW'(CMAX);
    localparam logic signed [XW-1:0] X_CMIN   = XW'(CMIN);
    localparam logic signed [XW-1:0] X_MAG    = XW'(MAG_MAX);
    localparam logic signed [XW-1:0] X_ROUND  = XW'(longint'(1) << 15);
    localparam logic [45:0]          PRE_RND  = 46'(longint'(1) << 13);
    localparam logic [63:0]          POST_RND = 64'(longint'(1) << 29);

    // Contents of one pipeline stage.
    typedef struct packed {
        logic                 dir;
        logic                 last;
        logic                 spec;
        logic                 spec_neg;
        logic [15:0]          spec_mag;
        logic signed [XW-1:0] x;
        logic signed [XW-1:0] y;
        logic [31:0]          z;
    } stage_t;

    stage_t          pipe_reg  [NST];
    stage_t          pipe_next [NST];
    logic [NST-1:0]  valid_reg;
    logic [NST-1:0]  valid_next;
    logic [NST:0]    en;
    logic            direction_reg;
    logic            direction_next;
    result_t         out_reg;
    result_t         out_next;
    logic            out_valid_reg;
    logic            out_valid_next;

    // Saturate a wide value into a range.
    function automatic logic signed [XW-1:0] clamp_x(
        input logic signed [XW-1:0] v,
        input logic signed [XW-1:0] lo,
        input logic signed [XW-1:0] hi
    );
        logic signed [XW-1:0] r;
        r = v;
        if (v < lo)
        begin
            r = lo;
        end
        else if (v > hi)
        begin
            r = hi;
        end
        return r;
    endfunction

    // Stage advance chain: a stage loads when it is empty or its content moves on.
    assign en[NST] = !out_valid_reg || result_ready;

    for (genvar k = 0; k < NST; k++)
    begin : g_adv
        assign en[k] = !valid_reg[k] || en[k+1];
    end

    assign sample_ready = en[0];
    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    // Direction register.
    assign direction_next = cfg_wr_en ? cfg_wr_data : direction_reg;

    // Valid bits move with the data.
    always_comb
    begin
        valid_next = valid_reg;
        if (en[0])
        begin
            valid_next[0] = sample_valid;
        end
        for (int k = 1; k < NST; k++)
        begin
            if (en[k])
            begin
                valid_next[k] = valid_reg[k-1];
            end
        end
        out_valid_next = en[NST] ? valid_reg[NST-1] : out_valid_reg;
    end

    // Stage 0: saturate the inputs to the range of the selected direction.
    always_comb
    begin
        logic signed [16:0] a_c;
        logic signed [15:0] b_c;
        a_c = sample.first_in;
        b_c = sample.second_in;
        if (direction_reg == DIR_RECT_TO_POLAR)
        begin
            if (sample.first_in > A_CMAX)
            begin
                a_c = A_CMAX;
            end
            else if (sample.first_in < A_CMIN)
            begin
                a_c = A_CMIN;
            end
            if (sample.second_in > B_CMAX)
            begin
                b_c = B_CMAX;
            end
            else if (sample.second_in < B_CMIN)
            begin
                b_c = B_CMIN;
            end
        end
        else
        begin
            if (sample.first_in < 17'sd0)
            begin
                a_c = '0;
            end
            else if (sample.first_in > A_MAG)
            begin
                a_c = A_MAG;
            end
        end
        pipe_next[0].dir      = direction_reg;
        pipe_next[0].last     = sample.last_in;
        pipe_next[0].spec     = 1'b0;
        pipe_next[0].spec_neg = 1'b0;
        pipe_next[0].spec_mag = '0;
        pipe_next[0].x        = XW'(a_c);
        pipe_next[0].y        = XW'(b_c);
        pipe_next[0].z        = '0;
    end

    // Stage 1: scale up and fold into the right half plane, or apply the gain
    // to the magnitude and load the phase.
    always_comb
    begin
        logic [45:0]          mag_prod;
        logic [45:0]          mag_rnd;
        logic signed [XW-1:0] xs;
        logic signed [XW-1:0] ys;
        mag_prod = 46'(pipe_reg[0].x[15:0]) * 46'(GAIN_Q30);
        mag_rnd  = mag_prod + PRE_RND;
        xs       = pipe_reg[0].x <<< 16;
        ys       = pipe_reg[0].y <<< 16;
        pipe_next[1] = pipe_reg[0];
        if (pipe_reg[0].dir == DIR_RECT_TO_POLAR)
        begin
            pipe_next[1].spec     = (pipe_reg[0].x == '0);
            pipe_next[1].spec_neg = pipe_reg[0].y[XW-1];
            pipe_next[1].spec_mag = pipe_reg[0].y[XW-1] ? 16'(-pipe_reg[0].y)
                                                         : 16'(pipe_reg[0].y);
            if (pipe_reg[0].x[XW-1])
            begin
                pipe_next[1].x = -xs;
                pipe_next[1].y = -ys;
                pipe_next[1].z = HALF_TURN;
            end
            else
            begin
                pipe_next[1].x = xs;
                pipe_next[1].y = ys;
                pipe_next[1].z = '0;
            end
        end
        else
        begin
            pipe_next[1].x = XW'(mag_rnd[45:14]);
            pipe_next[1].y = '0;
            pipe_next[1].z = {pipe_reg[0].y[15:0], 16'h0000};
        end
    end

    // Stage 2: in polar to rectangular mode, a phase in the left half plane is turned by a half turn and x is negated.
    always_comb
    begin
        pipe_next[2] = pipe_reg[1];
        if ((pipe_reg[1].dir == DIR_POLAR_TO_RECT) && (pipe_reg[1].z[31] ^ pipe_reg[1].z[30]))
        begin
            pipe_next[2].x = -pipe_reg[1].x;
            pipe_next[2].z = pipe_reg[1].z + HALF_TURN;
        end
    end

    // CORDIC micro-rotations, one per stage. Vectoring drives y to zero,
    // rotation drives the residual angle to zero.
    for (genvar i = 0; i < ITERATIONS; i++)
    begin : g_cordic
        always_comb
        begin
            logic signed [XW-1:0] dx;
            logic signed [XW-1:0] dy;
            logic                 up;
            dx = pipe_reg[CORDIC_0+i-1].y >>> i;
            dy = pipe_reg[CORDIC_0+i-1].x >>> i;
            up = (pipe_reg[CORDIC_0+i-1].dir == DIR_POLAR_TO_RECT)
                 ? pipe_reg[CORDIC_0+i-1].z[31] : !pipe_reg[CORDIC_0+i-1].y[XW-1];
            pipe_next[CORDIC_0+i] = pipe_reg[CORDIC_0+i-1];
            if (up)
            begin
                pipe_next[CORDIC_0+i].x = pipe_reg[CORDIC_0+i-1].x + dx;
                pipe_next[CORDIC_0+i].y = pipe_reg[CORDIC_0+i-1].y - dy;
                pipe_next[CORDIC_0+i].z = pipe_reg[CORDIC_0+i-1].z + ATAN_TURNS[i];
            end
            else
            begin
                pipe_next[CORDIC_0+i].x = pipe_reg[CORDIC_0+i-1].x - dx;
                pipe_next[CORDIC_0+i].y = pipe_reg[CORDIC_0+i-1].y + dy;
                pipe_next[CORDIC_0+i].z = pipe_reg[CORDIC_0+i-1].z - ATAN_TURNS[i];
            end
        end
    end

    // Post stage: in rectangular to polar mode, gain compensation of the magnitude (x is never negative here).
    always_comb
    begin
        logic [63:0] post_prod;
        logic [63:0] post_rnd;
        post_prod = 64'(pipe_reg[POST-1].x[33:0]) * 64'(GAIN_Q30);
        post_rnd  = post_prod + POST_RND;
        pipe_next[POST] = pipe_reg[POST-1];
        if (pipe_reg[POST-1].dir == DIR_RECT_TO_POLAR)
        begin
            pipe_next[POST].x = XW'(post_rnd[63:30]);
        end
    end

    // Output stage: drop the guard bits, saturate, and form the phase.
    always_comb
    begin
        logic signed [XW-1:0] xr;
        logic signed [XW-1:0] yr;
        logic [31:0]          zr;
        xr = (pipe_reg[NST-1].x + X_ROUND) >>> 16;
        yr = (pipe_reg[NST-1].y + X_ROUND) >>> 16;
        zr = pipe_reg[NST-1].z + PHASE_ROUNDER;
        out_next.last_out = pipe_reg[NST-1].last;
        if (pipe_reg[NST-1].dir == DIR_RECT_TO_POLAR)
        begin
            if (pipe_reg[NST-1].spec)
            begin
                out_next.first_out = ($signed({1'b0, pipe_reg[NST-1].spec_mag}) > A_MAG)
                                     ? A_MAG : $signed({1'b0, pipe_reg[NST-1].spec_mag});
                out_next.second_out = pipe_reg[NST-1].spec_neg ? QUARTER_TURN_NEG
                                                               : QUARTER_TURN_POS;
            end
            else
            begin
                out_next.first_out  = 17'(clamp_x(xr, '0, X_MAG));
                out_next.second_out = $signed(zr[31:16]);
            end
        end
        else
        begin
            out_next.first_out  = 17'(clamp_x(xr, X_CMIN, X_CMAX));
            out_next.second_out = 16'(clamp_x(yr, X_CMIN, X_CMAX));
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
            direction_reg <= DIR_RECT_TO_POLAR;
        end
        else
        begin
            valid_reg     <= valid_next;
            out_valid_reg <= out_valid_next;
            direction_reg <= direction_next;
        end
    end

    // Datapath registers load whenever their stage advances.
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < NST; k++)
        begin
            if (en[k])
            begin
                pipe_reg[k] <= pipe_next[k];
            end
        end
        if (en[NST])
        begin
            out_reg <= out_next;
        end
    end

`ifndef SYNTHESIS
    // An empty output register lets every stage move, so a new sample is taken.
    a_ready_when_drained: assert property (
        @(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> sample_ready
    ) else $error("sample_ready low while the output register is empty");

    // A stalled last stage keeps its sample.
    a_last_stage_holds: assert property (
        @(posedge clk) disable iff (!rst_n)
        valid_reg[NST-1] && !en[NST] |=> valid_reg[NST-1] && $stable(pipe_reg[NST-1])
    ) else $error("last pipeline stage lost or changed a stalled transaction");

    // The first result field stays inside the saturation limits.
    a_first_in_range: assert property (
        @(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_reg.first_out >= A_CMIN) && (out_reg.first_out <= A_HI)
    ) else $error("first_out outside its saturation range");
`endif

endmodule
